// ===== rtl/i2c_ram_pkg.sv =====
// shared types and constants of the i2c register access master
package i2c_ram_pkg;

  localparam int unsigned PhaseW = 16;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_RSVD  = 2'd3
  } i2c_ram_kind_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'd0,
    ST_ST0  = 5'd1,
    ST_ST1  = 5'd2,
    ST_ST2  = 5'd3,
    ST_ST3  = 5'd4,
    ST_W0   = 5'd5,
    ST_W1   = 5'd6,
    ST_W2   = 5'd7,
    ST_W3   = 5'd8,
    ST_W4   = 5'd9,
    ST_A0   = 5'd10,
    ST_A1   = 5'd11,
    ST_A2   = 5'd12,
    ST_R0   = 5'd13,
    ST_R1   = 5'd14,
    ST_R2   = 5'd15,
    ST_R3   = 5'd16,
    ST_R4   = 5'd17,
    ST_N0   = 5'd18,
    ST_N1   = 5'd19,
    ST_N2   = 5'd20,
    ST_P0   = 5'd21,
    ST_P1   = 5'd22,
    ST_P2   = 5'd23
  } i2c_ram_state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] device_addr;
    logic [7:0] reg_index;
    logic [7:0] write_data;
    logic       sda_in;
  } i2c_ram_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } i2c_ram_res_t;

endpackage

// ===== rtl/i2c_ram_core.sv =====
// bus sequencer: advances the i2c transaction by one tick per step
module i2c_ram_core import i2c_ram_pkg::*; #(
  parameter int unsigned ACK_POLL_LIMIT = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2c_ram_item_t       item_i,
  input  logic [PhaseW-1:0]   phase_ticks_i,
  output i2c_ram_res_t        res_o
);

  i2c_ram_state_e    state_q, state_d;
  logic [PhaseW-1:0] pc_q, pc_d;
  logic [3:0]        bc_q, bc_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        poll_q, poll_d;
  logic              rd_req_q, rd_req_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        idx_q, idx_d;
  logic [7:0]        data_q, data_d;
  logic              err_q, err_d;
  logic [2:0]        stage_q, stage_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              drv_q, drv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pc_q     <= '0;
      bc_q     <= '0;
      shift_q  <= '0;
      poll_q   <= '0;
      rd_req_q <= 1'b0;
      addr_q   <= '0;
      idx_q    <= '0;
      data_q   <= '0;
      err_q    <= 1'b0;
      stage_q  <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      drv_q    <= 1'b1;
    end else if (step_i) begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      bc_q     <= bc_d;
      shift_q  <= shift_d;
      poll_q   <= poll_d;
      rd_req_q <= rd_req_d;
      addr_q   <= addr_d;
      idx_q    <= idx_d;
      data_q   <= data_d;
      err_q    <= err_d;
      stage_q  <= stage_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      drv_q    <= drv_d;
    end
  end

  always_comb begin
    i2c_ram_state_e    cur;
    logic [PhaseW-1:0] pc_inc;
    logic [3:0]        bc_m1;
    logic [2:0]        stage_n;
    logic              done;

    state_d  = state_q;
    pc_d     = pc_q;
    bc_d     = bc_q;
    shift_d  = shift_q;
    poll_d   = poll_q;
    rd_req_d = rd_req_q;
    addr_d   = addr_q;
    idx_d    = idx_q;
    data_d   = data_q;
    err_d    = err_q;
    stage_d  = stage_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    drv_d    = drv_q;
    done     = 1'b0;
    pc_inc   = '0;
    stage_n  = '0;

    // new request while idle
    if (state_q == ST_IDLE &&
        (item_i.kind == KIND_WRITE || item_i.kind == KIND_READ)) begin
      rd_req_d = (item_i.kind == KIND_READ);
      addr_d   = item_i.device_addr;
      idx_d    = item_i.reg_index;
      data_d   = item_i.write_data;
      err_d    = 1'b0;
      stage_d  = '0;
      shift_d  = '0;
      bc_d     = '0;
      state_d  = ST_ST0;
      pc_d     = '0;
    end

    cur   = state_d;
    bc_m1 = bc_d - 4'd1;

    if (cur == ST_A1) begin
      if (!item_i.sda_in) begin
        state_d = ST_A2;
        pc_d    = '0;
      end else begin
        poll_d = poll_q + 8'd1;
        if (poll_d >= 8'(ACK_POLL_LIMIT)) begin
          err_d   = 1'b1;
          state_d = ST_A2;
          pc_d    = '0;
        end
      end
    end else if (cur != ST_IDLE) begin
      // line action at the first tick of a phase
      if (pc_d == '0) begin
        unique case (cur)
          ST_ST0, ST_W4, ST_N0, ST_P2: begin
            sda_d = 1'b1;
            drv_d = 1'b1;
          end
          ST_ST1, ST_W2, ST_R3, ST_N1, ST_P1: scl_d = 1'b1;
          ST_ST2, ST_P0: begin
            sda_d = 1'b0;
            drv_d = 1'b1;
          end
          ST_ST3, ST_W0, ST_W3, ST_A2, ST_R2, ST_R4, ST_N2: scl_d = 1'b0;
          ST_W1: begin
            sda_d = shift_d[bc_m1[2:0]];
            drv_d = 1'b1;
          end
          ST_A0: begin
            sda_d = 1'b1;
            drv_d = 1'b0;
            scl_d = 1'b1;
          end
          ST_R0: begin
            sda_d = 1'b1;
            drv_d = 1'b0;
            scl_d = 1'b0;
          end
          default: ;
        endcase
      end
      pc_inc = pc_d + 1'b1;
      pc_d   = pc_inc;
      if (pc_inc >= phase_ticks_i) begin
        pc_d = '0;
        unique case (cur)
          ST_ST3: begin
            shift_d = addr_d | {7'd0, (stage_d != '0)};
            bc_d    = 4'd8;
            state_d = ST_W0;
          end
          ST_W2: begin
            bc_d    = (bc_d != '0) ? bc_m1 : 4'd0;
            state_d = (bc_d != '0) ? ST_W0 : ST_W3;
          end
          ST_W4: begin
            poll_d  = '0;
            state_d = ST_A0;
          end
          ST_A2: begin
            stage_n = stage_d + 3'd1;
            stage_d = stage_n;
            if (stage_n == 3'd1) begin
              shift_d = idx_d;
              bc_d    = 4'd8;
              state_d = ST_W0;
            end else if (stage_n == 3'd2) begin
              if (rd_req_d) begin
                state_d = ST_ST0;
              end else begin
                shift_d = data_d;
                bc_d    = 4'd8;
                state_d = ST_W0;
              end
            end else if (stage_n == 3'd3 && rd_req_d) begin
              shift_d = '0;
              bc_d    = 4'd8;
              state_d = ST_R0;
            end else begin
              state_d = ST_P0;
            end
          end
          ST_R3: begin
            shift_d = {shift_d[6:0], item_i.sda_in};
            bc_d    = (bc_d != '0) ? bc_m1 : 4'd0;
            state_d = (bc_d != '0) ? ST_R2 : ST_R4;
          end
          ST_R4: state_d = ST_N0;
          ST_P2: begin
            done    = 1'b1;
            state_d = ST_IDLE;
          end
          ST_ST0, ST_ST1, ST_ST2, ST_W0, ST_W1, ST_W3, ST_A0, ST_R0, ST_R1,
          ST_R2, ST_N0, ST_N1, ST_N2, ST_P0, ST_P1: begin
            state_d = i2c_ram_state_e'(cur + 5'd1);
          end
          default: state_d = ST_IDLE;
        endcase
      end
    end

    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.sda_drive = drv_d;
    res_o.busy_res  = (state_d != ST_IDLE);
    res_o.done_res  = done;
    res_o.read_byte = (done && rd_req_d) ? shift_d : 8'd0;
    res_o.ack_error = err_d;
  end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
// top level of the i2c register access master with stream ports
// Each accepted input transaction is one timing tick of the i2c sequencer and yields exactly
// one result transaction, registered and shown from the cycle after acceptance. A tick is
// accepted every clock as long as the result side takes its transactions; the single output
// register sets that figure. A tick may start a byte write or a byte read while no access is
// in progress; every bus phase lasts phase_ticks ticks (one tick when phase_ticks is zero),
// which the user must write through the cfg channel only while idle (not enforced), and the
// acknowledge is polled once per tick up to ACK_POLL_LIMIT ticks before ack_error is set.
module i2c_register_access_master import i2c_ram_pkg::*; #(
  parameter int unsigned ACK_POLL_LIMIT = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // device_addr[7:0], reg_index[15:8], write_data[23:16], sda_in[24], zero fill
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // read_byte[12:5], ack_error[13], zero fill
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [PhaseW-1:0] phase_ticks_q;
  logic              out_valid_q;
  i2c_ram_res_t      res_q;
  i2c_ram_res_t      res;
  i2c_ram_item_t     item;
  logic              step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseW'(4);
    end else if (cfg_valid_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  assign item.kind        = s_axis_tuser;
  assign item.device_addr = s_axis_tdata[7:0];
  assign item.reg_index   = s_axis_tdata[15:8];
  assign item.write_data  = s_axis_tdata[23:16];
  assign item.sda_in      = s_axis_tdata[24];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  i2c_ram_core #(
    .ACK_POLL_LIMIT(ACK_POLL_LIMIT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (item),
    .phase_ticks_i(phase_ticks_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.ack_error, res_q.read_byte, res_q.done_res,
                          res_q.busy_res, res_q.sda_drive, res_q.sda_level, res_q.scl_level};

endmodule

// ===== sim/i2c_ram_checker.sv =====
// i2c register access master checker: tick predictor and result stream comparison
`timescale 1ns / 100ps

module i2c_ram_checker import i2c_ram_pkg::*; #(
  parameter int unsigned ACK_POLL_LIMIT = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // device_addr[7:0], reg_index[15:8], write_data[23:16], sda_in[24], zero fill
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // read_byte[12:5], ack_error[13], zero fill
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          backlog_o
);

  i2c_ram_state_e seq_state;
  logic [31:0]    phase_count;
  logic [3:0]     bits_left;
  logic [7:0]     shift_reg;
  logic [7:0]     poll_count;
  logic           req_read;
  logic [7:0]     req_addr;
  logic [7:0]     req_index;
  logic [7:0]     req_data;
  logic           err_sticky;
  logic           scl_q;
  logic           sda_q;
  logic           drv_q;
  logic [2:0]     byte_stage;
  logic [15:0]    phase_ticks;
  i2c_ram_res_t   line_results_q[$];

  task automatic enter_state(input i2c_ram_state_e s);
    seq_state = s;
    phase_count = '0;
  endtask

  task automatic drive_sda(input logic v);
    drv_q = 1'b1;
    sda_q = v;
  endtask

  task automatic release_sda();
    drv_q = 1'b0;
    sda_q = 1'b1;
  endtask

  task automatic load_tx_byte(input logic [7:0] b);
    shift_reg = b;
    bits_left = 4'd8;
    enter_state(ST_W0);
  endtask

  task automatic phase_entry(input i2c_ram_state_e s);
    case (s)
      ST_ST0, ST_W4, ST_N0, ST_P2: drive_sda(1'b1);
      ST_ST1, ST_W2, ST_R3, ST_N1, ST_P1: scl_q = 1'b1;
      ST_ST2, ST_P0: drive_sda(1'b0);
      ST_ST3, ST_W0, ST_W3, ST_A2, ST_R2, ST_R4, ST_N2: scl_q = 1'b0;
      ST_W1: drive_sda(shift_reg[3'(bits_left - 4'd1)]);
      ST_A0: begin
        release_sda();
        scl_q = 1'b1;
      end
      ST_R0: begin
        release_sda();
        scl_q = 1'b0;
      end
      default: ;
    endcase
  endtask

  // pick the next byte once an acknowledge slot is over
  task automatic next_byte();
    byte_stage = byte_stage + 3'd1;
    if (byte_stage == 3'd1) begin
      load_tx_byte(req_index);
    end else if (byte_stage == 3'd2) begin
      if (req_read) enter_state(ST_ST0);
      else load_tx_byte(req_data);
    end else if (byte_stage == 3'd3 && req_read) begin
      shift_reg = '0;
      bits_left = 4'd8;
      enter_state(ST_R0);
    end else begin
      enter_state(ST_P0);
    end
  endtask

  task automatic phase_exit(input i2c_ram_state_e s, input logic sda,
                            inout logic done, inout logic [7:0] rd);
    case (s)
      ST_ST3: load_tx_byte(req_addr | {7'd0, byte_stage != 3'd0});
      ST_W2: begin
        bits_left = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;
        enter_state((bits_left != 4'd0) ? ST_W0 : ST_W3);
      end
      ST_W4: begin
        poll_count = '0;
        enter_state(ST_A0);
      end
      ST_A2: next_byte();
      ST_R3: begin
        shift_reg = {shift_reg[6:0], sda};
        bits_left = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;
        enter_state((bits_left != 4'd0) ? ST_R2 : ST_R4);
      end
      ST_R4: enter_state(ST_N0);
      ST_P2: begin
        done = 1'b1;
        rd = req_read ? shift_reg : 8'd0;
        enter_state(ST_IDLE);
      end
      default: enter_state(i2c_ram_state_e'(s + 5'd1));
    endcase
  endtask

  task automatic bus_tick(input logic [1:0] kind, input logic [7:0] addr, idx, wdata,
                          input logic sda, output i2c_ram_res_t res);
    i2c_ram_state_e cur;
    logic           done;
    logic [7:0]     rd;
    done = 1'b0;
    rd = '0;
    if (seq_state == ST_IDLE && (kind == KIND_WRITE || kind == KIND_READ)) begin
      req_read = (kind == KIND_READ);
      req_addr = addr;
      req_index = idx;
      req_data = wdata;
      err_sticky = 1'b0;
      byte_stage = '0;
      shift_reg = '0;
      bits_left = '0;
      enter_state(ST_ST0);
    end
    if (seq_state == ST_A1) begin
      if (!sda) begin
        enter_state(ST_A2);
      end else begin
        poll_count = poll_count + 8'd1;
        if (poll_count >= ACK_POLL_LIMIT) begin
          err_sticky = 1'b1;
          enter_state(ST_A2);
        end
      end
    end else if (seq_state != ST_IDLE) begin
      cur = seq_state;
      if (phase_count == 0) phase_entry(cur);
      phase_count = phase_count + 1;
      if (phase_count >= {16'd0, phase_ticks}) phase_exit(cur, sda, done, rd);
    end
    res.scl_level = scl_q;
    res.sda_level = sda_q;
    res.sda_drive = drv_q;
    res.busy_res  = (seq_state != ST_IDLE);
    res.done_res  = done;
    res.read_byte = rd;
    res.ack_error = err_sticky;
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      mismatch_count_o++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    i2c_ram_res_t want;
    i2c_ram_res_t got;
    if (!rst_ni) begin
      seq_state = ST_IDLE;
      phase_count = '0;
      bits_left = '0;
      shift_reg = '0;
      poll_count = '0;
      req_read = 1'b0;
      req_addr = '0;
      req_index = '0;
      req_data = '0;
      err_sticky = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drv_q = 1'b1;
      byte_stage = '0;
      phase_ticks = 16'd4;
      line_results_q.delete();
      mismatch_count_o = 0;
      backlog_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bus_tick(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                 s_axis_tdata[24], want);
        line_results_q.push_back(want);
      end
      // a register write takes effect from the next tick on
      if (cfg_valid_i && cfg_ready_i) phase_ticks = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got.scl_level = m_axis_tdata[0];
        got.sda_level = m_axis_tdata[1];
        got.sda_drive = m_axis_tdata[2];
        got.busy_res  = m_axis_tdata[3];
        got.done_res  = m_axis_tdata[4];
        got.read_byte = m_axis_tdata[12:5];
        got.ack_error = m_axis_tdata[13];
        if (line_results_q.size() == 0) begin
          mismatch_count_o++;
          $error("result transaction with no tick waiting");
        end else begin
          want = line_results_q.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("sda_drive", want.sda_drive, got.sda_drive);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("ack_error", want.ack_error, got.ack_error);
        end
      end
      backlog_o = line_results_q.size();
    end
  end

endmodule

// ===== sim/i2c_register_access_master_tb.sv =====
// i2c register access master testbench: stimulus, stalls and verdict
`timescale 1ns / 100ps

module i2c_register_access_master_tb import i2c_ram_pkg::*;;

  localparam int unsigned PollLimit = 255;
  localparam int CycleLimit = 2_000_000;
  localparam int BusyBit = 3;

  localparam int SdaAck    = 0;
  localparam int SdaHigh   = 1;
  localparam int SdaRandom = 2;

  localparam logic [1:0] RxFree    = 2'd0;
  localparam logic [1:0] RxSparse  = 2'd1;
  localparam logic [1:0] RxPattern = 2'd2;
  localparam logic [1:0] RxSlow    = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  int          mismatches;
  int          backlog;
  int          ticks_sent = 0;
  int          ticks_back = 0;
  logic        last_busy = 1'b0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          sda_bias = 0;
  logic [1:0]  rx_mode = RxFree;
  int          rx_left = 0;
  logic [7:0]  rx_pattern = 8'b1101_0010;

  i2c_register_access_master #(
    .ACK_POLL_LIMIT(PollLimit)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  i2c_ram_checker #(
    .ACK_POLL_LIMIT(PollLimit)
  ) checker_i (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i,
    .mismatch_count_o(mismatches),
    .backlog_o(backlog)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) ticks_sent <= ticks_sent + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      ticks_back <= ticks_back + 1;
      last_busy <= m_axis_tdata[BusyBit];
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxFree:    m_axis_tready <= 1'b1;
      RxSparse:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RxPattern: m_axis_tready <= rx_pattern[0];
      default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
    rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
  end

  task automatic send_tick(input i2c_ram_kind_e kind, input logic [7:0] addr, idx, wdata,
                           input logic sda);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 32);
    end
    s_axis_tdata = {7'd0, sda, wdata, idx, addr};
    s_axis_tuser = kind;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic pick_sda(input int mode);
    case (mode)
      SdaAck:  return ($urandom_range(0, 3) == 0);
      SdaHigh: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // plain ticks until the access is over and every result is back
  task automatic drain_to_idle(input int mode);
    while (!(ticks_back == ticks_sent && !last_busy)) begin
      if (ticks_back == ticks_sent)
        send_tick(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), pick_sda(mode));
      else
        @(negedge clk_i);
    end
  endtask

  task automatic write_phase_ticks(input logic [15:0] v);
    cfg_data_i = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_ticks(input int count);
    int            r;
    i2c_ram_kind_e kind;
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0: sda_bias = 0;
          1: sda_bias = 1;
          2: sda_bias = 4;
          default: sda_bias = 7;
        endcase
      end
      r = $urandom_range(0, 31);
      kind = (r < 24) ? KIND_TICK : (r < 28) ? KIND_WRITE : (r < 31) ? KIND_READ : KIND_RSVD;
      send_tick(kind, 8'($urandom), 8'($urandom), 8'($urandom),
                $urandom_range(0, 7) < sda_bias);
    end
  endtask

  initial begin
    logic [15:0] settings[2];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_TICK;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    settings[0] = 16'd0;
    settings[1] = 16'($urandom_range(2, 4));
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset phase length, directed accesses
    send_tick(KIND_RSVD, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_tick(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
    send_tick(KIND_WRITE, 8'hFE, 8'h00, 8'hFF, 1'b0);
    send_tick(KIND_READ, 8'h00, 8'hFF, 8'h00, 1'b0);
    drain_to_idle(SdaAck);
    write_phase_ticks(16'd1);
    send_tick(KIND_READ, 8'hFF, 8'hFF, 8'h00, 1'b1);
    drain_to_idle(SdaRandom);
    // no acknowledge on the address byte
    send_tick(KIND_WRITE, 8'h00, 8'hA5, 8'h5A, 1'b1);
    repeat (300)
      send_tick(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), pick_sda(SdaHigh));
    drain_to_idle(SdaAck);
    // error flag clears on the next access
    send_tick(KIND_WRITE, 8'h3C, 8'h7E, 8'h00, 1'b0);
    drain_to_idle(SdaAck);

    foreach (settings[i]) begin
      write_phase_ticks(settings[i]);
      random_ticks(80);
      drain_to_idle(SdaAck);
    end
    // longest phase, left running at the end
    write_phase_ticks(16'hFFFF);
    random_ticks(40);

    wait (ticks_back == ticks_sent);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && backlog == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
